[hdl/lef_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lef_pkg;

  // Field widths of the ports
  localparam int CH_W       = 8;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  // Image size after reset
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  // Entries of the queue between the window pipeline and the result emitter
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // Input word: one raster-order pixel
  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } in_word_t;

  // Result word: one filtered pixel with its position
  typedef struct packed {
    logic [COL_W-1:0] col_out;
    logic [ROW_W-1:0] row_out;
    logic [CH_W-1:0]  red_out;
    logic [CH_W-1:0]  green_out;
    logic [CH_W-1:0]  blue_out;
    logic             image_done;
  } out_word_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // One column of the 3x3 window: rows y-2, y-1, y
  typedef struct packed {
    rgb_t top;
    rgb_t mid;
    rgb_t bot;
  } win_col_t;

  // Which result words one pixel releases, in output order
  typedef struct packed {
    logic main;
    logic right;
    logic bottom;
    logic last;
  } emit_t;

  // Coordinates the results of one pixel draw from: x-1, x, y-1, y
  typedef struct packed {
    logic [COL_W-1:0] col_prev;
    logic [COL_W-1:0] col_cur;
    logic [ROW_W-1:0] row_prev;
    logic [ROW_W-1:0] row_cur;
  } coord_t;

  // Classified pixel traveling through the window pipeline
  typedef struct packed {
    coord_t pos;
    emit_t  emit;
    logic   lap_en;
    rgb_t   pix;
  } tag_t;

  // Queue entry handed to the emitter
  typedef struct packed {
    coord_t pos;
    emit_t  emit;
    rgb_t   val;
  } rec_t;

endpackage

`default_nettype wire

[hdl/laplacian_edge_filter_3x3.sv]
`timescale 1ns / 1ps
`default_nettype none

// 3x3 Laplacian edge filter on a raster-order RGB stream. One pixel is accepted per clock while
// in_stall is low; it passes stage A, stage B, the queue and the output register, and one result
// word leaves per clock while out_stall is low. Each pixel of rows 1..H-2 but the first of a row
// yields one word (two at the end of a row), so those rows run at one pixel per clock when the
// receiver does not stall; on the last row each pixel but the first yields two words and the
// single output port sets the pace, with a four-entry queue absorbing the bursts (the final
// pixel yields four words). The two line stores share one MAX_WIDTH x 48 memory, read when a
// pixel is accepted and written one stage later. Width and height writes saturate to 3..MAX_WIDTH
// and 3..MAX_HEIGHT and should only be made while the block is idle. Results carry their column
// and row; borders read zero and image_done flags the word for the bottom-right pixel.
module laplacian_edge_filter_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lef_pkg::in_word_t               in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lef_pkg::out_word_t              out_word,
  input  logic                            cfg_we,
  input  logic [lef_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lef_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic           rd_en;
  logic [CW-1:0]  rd_x;
  logic           a_valid;
  lef_pkg::tag_t  a_tag;
  logic [CW-1:0]  a_x;
  logic           a_take;
  logic           q_room;
  logic           q_push;
  lef_pkg::rec_t  q_rec;
  logic           head_valid;
  lef_pkg::rec_t  head;
  logic           pop;

  lef_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rd_en     (rd_en),
    .rd_x      (rd_x),
    .a_valid   (a_valid),
    .a_tag     (a_tag),
    .a_x       (a_x),
    .a_take    (a_take)
  );

  lef_exec #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_exec (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_x    (rd_x),
    .a_valid (a_valid),
    .a_tag   (a_tag),
    .a_x     (a_x),
    .a_take  (a_take),
    .q_room  (q_room),
    .q_push  (q_push),
    .q_rec   (q_rec)
  );

  lef_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_rec   (q_rec),
    .room       (q_room),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  lef_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

endmodule

`default_nettype wire

[hdl/lef_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module lef_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lef_pkg::in_word_t                   in_word,
  input  logic                                cfg_we,
  input  logic [lef_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lef_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                rd_en,
  output logic [$clog2(MAX_WIDTH)-1:0]        rd_x,
  output logic                                a_valid,
  output lef_pkg::tag_t                       a_tag,
  output logic [$clog2(MAX_WIDTH)-1:0]        a_x,
  input  logic                                a_take
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int RW1  = RW + 1;
  localparam int COLW = lef_pkg::COL_W;
  localparam int ROWW = lef_pkg::ROW_W;
  localparam logic [CW-1:0] WM1_RESET = CW'((lef_pkg::WIDTH_RESET > MAX_WIDTH) ?
                                            MAX_WIDTH - 1 : lef_pkg::WIDTH_RESET - 1);
  localparam logic [RW-1:0] HM1_RESET = RW'((lef_pkg::HEIGHT_RESET > MAX_HEIGHT) ?
                                            MAX_HEIGHT - 1 : lef_pkg::HEIGHT_RESET - 1);

  logic [CW-1:0]  wm1_r, wm1_nxt;
  logic [RW-1:0]  hm1_r, hm1_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic           a_valid_r, a_valid_nxt;
  lef_pkg::tag_t  a_tag_r, a_tag_nxt;
  logic [CW-1:0]  a_x_r;

  logic           acc;
  logic           wrap_col;
  logic [RW1-1:0] y_inc;
  logic [CW-1:0]  x_cur;
  logic [RW-1:0]  y_cur;
  logic           x_last, y_last, x_zero, y_zero;
  logic [31:0]    wv, hv;

  // Saturate size writes to the supported range, keep size minus one
  always_comb begin
    wv      = 32'(cfg_data[lef_pkg::IMG_W_W-1:0]);
    hv      = 32'(cfg_data[lef_pkg::IMG_H_W-1:0]);
    wm1_nxt = wm1_r;
    hm1_nxt = hm1_r;
    if (cfg_we) begin
      unique case (lef_pkg::cfg_reg_t'(cfg_index))
        lef_pkg::REG_IMAGE_WIDTH: begin
          if (wv < 32'd3)                    wm1_nxt = CW'(2);
          else if (wv > 32'(MAX_WIDTH))      wm1_nxt = CW'(MAX_WIDTH - 1);
          else                               wm1_nxt = CW'(wv - 32'd1);
        end
        lef_pkg::REG_IMAGE_HEIGHT: begin
          if (hv < 32'd3)                    hm1_nxt = RW'(2);
          else if (hv > 32'(MAX_HEIGHT))     hm1_nxt = RW'(MAX_HEIGHT - 1);
          else                               hm1_nxt = RW'(hv - 32'd1);
        end
      endcase
    end
  end

  // Fix up the position if the size shrank, then classify the pixel
  always_comb begin
    wrap_col = col_r > wm1_r;
    x_cur    = wrap_col ? '0 : col_r;
    y_inc    = {1'b0, row_r} + RW1'(wrap_col);
    y_cur    = (y_inc > {1'b0, hm1_r}) ? '0 : y_inc[RW-1:0];
    x_last   = x_cur == wm1_r;
    y_last   = y_cur == hm1_r;
    x_zero   = x_cur == '0;
    y_zero   = y_cur == '0;

    a_tag_nxt.pos.col_prev = COLW'(x_cur) - COLW'(1);
    a_tag_nxt.pos.col_cur  = COLW'(x_cur);
    a_tag_nxt.pos.row_prev = ROWW'(y_cur) - ROWW'(1);
    a_tag_nxt.pos.row_cur  = ROWW'(y_cur);
    a_tag_nxt.emit.main    = !y_zero && !x_zero;
    a_tag_nxt.emit.right   = !y_zero && x_last;
    a_tag_nxt.emit.bottom  = y_last && !x_zero;
    a_tag_nxt.emit.last    = y_last && x_last;
    a_tag_nxt.lap_en       = (x_cur > CW'(1)) && (y_cur > RW'(1));
    a_tag_nxt.pix.red      = in_word.red_in;
    a_tag_nxt.pix.green    = in_word.green_in;
    a_tag_nxt.pix.blue     = in_word.blue_in;
  end

  // Accept when stage A is free or drains this cycle
  always_comb begin
    in_stall    = a_valid_r && !a_take;
    acc         = in_valid && !in_stall;
    a_valid_nxt = acc ? 1'b1 : (a_take ? 1'b0 : a_valid_r);
    col_nxt     = col_r;
    row_nxt     = row_r;
    if (acc) begin
      if (x_last) begin
        col_nxt = '0;
        row_nxt = y_last ? '0 : y_cur + RW'(1);
      end else begin
        col_nxt = x_cur + CW'(1);
        row_nxt = y_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm1_r     <= WM1_RESET;
      hm1_r     <= HM1_RESET;
      col_r     <= '0;
      row_r     <= '0;
      a_valid_r <= 1'b0;
    end else begin
      wm1_r     <= wm1_nxt;
      hm1_r     <= hm1_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      a_valid_r <= a_valid_nxt;
    end
  end

  // Hold the accepted pixel in stage A
  always_ff @(posedge clk) begin
    if (acc) begin
      a_tag_r <= a_tag_nxt;
      a_x_r   <= x_cur;
    end
  end

  assign rd_en   = acc;
  assign rd_x    = x_cur;
  assign a_valid = a_valid_r;
  assign a_tag   = a_tag_r;
  assign a_x     = a_x_r;

  // The final pixel of an image also closes its row and its last row
  a_last_implies_edges: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && a_tag_r.emit.last) |-> (a_tag_r.emit.right && a_tag_r.emit.bottom))
    else $error("final pixel without right and bottom results");

  // An accepted pixel occupies stage A on the next cycle
  acc_fills_a: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> a_valid_r)
    else $error("accepted pixel lost before stage A");

endmodule

`default_nettype wire

[hdl/lef_exec.sv]
`timescale 1ns / 1ps
`default_nettype none

module lef_exec #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]  rd_x,
  input  logic                          a_valid,
  input  lef_pkg::tag_t                 a_tag,
  input  logic [$clog2(MAX_WIDTH)-1:0]  a_x,
  output logic                          a_take,
  input  logic                          q_room,
  output logic                          q_push,
  output lef_pkg::rec_t                 q_rec
);

  typedef struct packed {
    lef_pkg::rgb_t upper;
    lef_pkg::rgb_t middle;
  } line_pair_t;

  line_pair_t         line_mem [MAX_WIDTH];
  line_pair_t         rd_r;
  lef_pkg::win_col_t  win0_r, win1_r, win2_r;
  logic               b_valid_r, b_valid_nxt;
  lef_pkg::tag_t      b_tag_r;
  logic               b_take;
  lef_pkg::rgb_t      lap;

  // 8*centre minus the eight neighbors, clamped to 0..255
  function automatic logic [7:0] lap_chan(input logic [7:0] ctr,
                                          input logic [7:0] n0, input logic [7:0] n1,
                                          input logic [7:0] n2, input logic [7:0] n3,
                                          input logic [7:0] n4, input logic [7:0] n5,
                                          input logic [7:0] n6, input logic [7:0] n7);
    logic [10:0]        nsum;
    logic signed [12:0] diff;
    logic [7:0]         res;
    nsum = 11'(n0) + 11'(n1) + 11'(n2) + 11'(n3) + 11'(n4) + 11'(n5) + 11'(n6) + 11'(n7);
    diff = $signed({2'b00, ctr, 3'b000}) - $signed({2'b00, nsum});
    if (diff < 0)               res = 8'd0;
    else if (diff > 13'sd255)   res = 8'd255;
    else                        res = diff[7:0];
    return res;
  endfunction

  // Advance stage A when stage B is free or drains
  always_comb begin
    b_take      = b_valid_r && q_room;
    a_take      = a_valid && (!b_valid_r || b_take);
    b_valid_nxt = a_take ? 1'b1 : (b_take ? 1'b0 : b_valid_r);
  end

  // Line store: read the column at accept, write it back as stage A drains
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= line_mem[rd_x];
    end
    if (a_take) begin
      line_mem[a_x] <= line_pair_t'{upper: rd_r.middle, middle: a_tag.pix};
    end
  end

  // Shift the window and load the new column
  always_ff @(posedge clk) begin
    if (a_take) begin
      win0_r  <= win1_r;
      win1_r  <= win2_r;
      win2_r  <= lef_pkg::win_col_t'{top: rd_r.upper, mid: rd_r.middle, bot: a_tag.pix};
      b_tag_r <= a_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
    end
  end

  // Filter the window centre per channel
  always_comb begin
    lap.red   = lap_chan(win1_r.mid.red,
                         win0_r.top.red, win0_r.mid.red, win0_r.bot.red,
                         win1_r.top.red, win1_r.bot.red,
                         win2_r.top.red, win2_r.mid.red, win2_r.bot.red);
    lap.green = lap_chan(win1_r.mid.green,
                         win0_r.top.green, win0_r.mid.green, win0_r.bot.green,
                         win1_r.top.green, win1_r.bot.green,
                         win2_r.top.green, win2_r.mid.green, win2_r.bot.green);
    lap.blue  = lap_chan(win1_r.mid.blue,
                         win0_r.top.blue, win0_r.mid.blue, win0_r.bot.blue,
                         win1_r.top.blue, win1_r.bot.blue,
                         win2_r.top.blue, win2_r.mid.blue, win2_r.bot.blue);
  end

  // Queue only pixels that release at least one word; borders read zero
  always_comb begin
    q_push     = b_take && (b_tag_r.emit != '0);
    q_rec.pos  = b_tag_r.pos;
    q_rec.emit = b_tag_r.emit;
    q_rec.val  = b_tag_r.lap_en ? lap : '0;
  end

endmodule

`default_nettype wire

[hdl/lef_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module lef_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lef_pkg::rec_t  push_rec,
  output logic           room,
  output logic           head_valid,
  output lef_pkg::rec_t  head,
  input  logic           pop
);

  localparam int DEPTH = lef_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  lef_pkg::rec_t  slots_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]  count_r, count_nxt;

  // Advance pointers with wrap, track fill
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    count_nxt  = count_r + NW'(push) - NW'(pop);
    room       = count_r != NW'(DEPTH);
    head_valid = count_r != '0;
    head       = slots_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_rec;
    end
  end

  no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != NW'(DEPTH)))
    else $error("push into a full queue");

  no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("pop from an empty queue");

endmodule

`default_nettype wire

[hdl/lef_emit.sv]
`timescale 1ns / 1ps
`default_nettype none

module lef_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  lef_pkg::rec_t      head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output lef_pkg::out_word_t out_word
);

  lef_pkg::emit_t     rem_r, rem_nxt;
  logic               started_r, started_nxt;
  logic               out_valid_r, out_valid_nxt;
  lef_pkg::out_word_t out_word_r, word_nxt;
  lef_pkg::emit_t     rem, pick, rem_left;
  logic               load;

  // Pick the next pending word of the head entry
  always_comb begin
    rem  = started_r ? rem_r : head.emit;
    load = head_valid && (!out_valid_r || !out_stall);
    pick = '0;
    priority if (rem.main)   pick.main   = 1'b1;
    else if (rem.right)      pick.right  = 1'b1;
    else if (rem.bottom)     pick.bottom = 1'b1;
    else if (rem.last)       pick.last   = 1'b1;
    else                     pick        = '0;
    rem_left = lef_pkg::emit_t'(rem & ~pick);
    pop      = load && (rem_left == '0);
  end

  // Build the word: filtered centre first, then zero border words
  always_comb begin
    word_nxt.col_out    = head.pos.col_prev;
    word_nxt.row_out    = head.pos.row_prev;
    word_nxt.red_out    = head.val.red;
    word_nxt.green_out  = head.val.green;
    word_nxt.blue_out   = head.val.blue;
    word_nxt.image_done = 1'b0;
    priority if (pick.right) begin
      word_nxt.col_out   = head.pos.col_cur;
      word_nxt.red_out   = '0;
      word_nxt.green_out = '0;
      word_nxt.blue_out  = '0;
    end else if (pick.bottom) begin
      word_nxt.row_out   = head.pos.row_cur;
      word_nxt.red_out   = '0;
      word_nxt.green_out = '0;
      word_nxt.blue_out  = '0;
    end else if (pick.last) begin
      word_nxt.col_out    = head.pos.col_cur;
      word_nxt.row_out    = head.pos.row_cur;
      word_nxt.red_out    = '0;
      word_nxt.green_out  = '0;
      word_nxt.blue_out   = '0;
      word_nxt.image_done = 1'b1;
    end else begin
      // keep the filtered centre word
      word_nxt.image_done = 1'b0;
    end
  end

  // Track partial progress on the head entry and the output register
  always_comb begin
    started_nxt   = load ? (rem_left != '0) : started_r;
    rem_nxt       = load ? rem_left : rem_r;
    out_valid_nxt = load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      started_r   <= started_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word_r <= word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  one_word_per_load: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> $onehot(pick))
    else $error("emitter loaded without exactly one pending word");

  head_kept_while_started: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> head_valid)
    else $error("queue head vanished during a partial entry");

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_W        = 1024;
  localparam int MAX_H        = 4096;
  // cycles to let a pixel that yields no result clear the window pipeline
  localparam int PIPE_SETTLE  = 8;
  localparam int DRAIN_LIMIT  = 4000;
  localparam int REPORT_LIMIT = 40;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  lef_pkg::in_word_t              in_word   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  lef_pkg::out_word_t             out_word;
  logic                           cfg_we    = 1'b0;
  logic [lef_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [lef_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  laplacian_edge_filter_3x3 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Filter state mirrored by the testbench
  logic [lef_pkg::IMG_W_W-1:0] img_width_reg;
  logic [lef_pkg::IMG_H_W-1:0] img_height_reg;
  lef_pkg::rgb_t               upper_line  [MAX_W];
  lef_pkg::rgb_t               middle_line [MAX_W];
  lef_pkg::win_col_t           window_cols [3];   // columns x-2, x-1, x
  int unsigned                 next_col;
  int unsigned                 next_row;
  lef_pkg::out_word_t          filtered_queue [$];

  int unsigned        err_count   = 0;
  int unsigned        pixels_sent = 0;
  bit                 idle_en     = 1'b1;
  int unsigned        stall_left  = 0;

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= REPORT_LIMIT)
      $display("ERROR %0t: %s", $time, msg);
  endtask

  function automatic void reset_filter_state();
    img_width_reg  = lef_pkg::IMG_W_W'(lef_pkg::WIDTH_RESET);
    img_height_reg = lef_pkg::IMG_H_W'(lef_pkg::HEIGHT_RESET);
    for (int i = 0; i < MAX_W; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    for (int k = 0; k < 3; k++)
      window_cols[k] = '0;
    next_col = 0;
    next_row = 0;
  endfunction

  function automatic int unsigned eff_width();
    if (img_width_reg < 3) return 3;
    if (img_width_reg > MAX_W) return MAX_W;
    return img_width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (img_height_reg < 3) return 3;
    if (img_height_reg > MAX_H) return MAX_H;
    return img_height_reg;
  endfunction

  function automatic logic [lef_pkg::CH_W-1:0] clamp_level(int v);
    if (v < 0) return '0;
    if (v > 255) return 8'hFF;
    return lef_pkg::CH_W'(v);
  endfunction

  // 8 * centre minus the eight neighbours, per channel
  function automatic lef_pkg::rgb_t laplace_window();
    int            sum_r, sum_g, sum_b;
    lef_pkg::rgb_t px;
    lef_pkg::rgb_t res;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < 3; r++) begin
        px = (r == 0) ? window_cols[k].top : (r == 1) ? window_cols[k].mid : window_cols[k].bot;
        sum_r += int'(px.red);
        sum_g += int'(px.green);
        sum_b += int'(px.blue);
      end
    end
    res.red   = clamp_level(9 * int'(window_cols[1].mid.red) - sum_r);
    res.green = clamp_level(9 * int'(window_cols[1].mid.green) - sum_g);
    res.blue  = clamp_level(9 * int'(window_cols[1].mid.blue) - sum_b);
    return res;
  endfunction

  function automatic void queue_result(int unsigned col, int unsigned row, lef_pkg::rgb_t v,
                                       logic done);
    lef_pkg::out_word_t w;
    w.col_out    = col[lef_pkg::COL_W-1:0];
    w.row_out    = row[lef_pkg::ROW_W-1:0];
    w.red_out    = v.red;
    w.green_out  = v.green;
    w.blue_out   = v.blue;
    w.image_done = done;
    filtered_queue.push_back(w);
  endfunction

  // Advance the mirrored filter by one pixel and queue the words it releases
  function automatic void filter_pixel(lef_pkg::in_word_t px);
    int unsigned   w, h, x, y;
    lef_pkg::rgb_t cur;
    w = eff_width();
    h = eff_height();
    x = next_col;
    y = next_row;
    if (x >= w) begin
      x = 0;
      y++;
    end
    if (y >= h) y = 0;
    cur.red   = px.red_in;
    cur.green = px.green_in;
    cur.blue  = px.blue_in;
    window_cols[0]     = window_cols[1];
    window_cols[1]     = window_cols[2];
    window_cols[2].top = upper_line[x];
    window_cols[2].mid = middle_line[x];
    window_cols[2].bot = cur;
    upper_line[x]      = middle_line[x];
    middle_line[x]     = cur;
    if (y >= 1 && x >= 1)
      queue_result(x - 1, y - 1,
                   (x >= 2 && y >= 2) ? laplace_window() : lef_pkg::rgb_t'('0), 1'b0);
    if (y >= 1 && x == w - 1)
      queue_result(w - 1, y - 1, '0, 1'b0);
    if (y == h - 1 && x >= 1)
      queue_result(x - 1, h - 1, '0, 1'b0);
    if (y == h - 1 && x == w - 1)
      queue_result(w - 1, h - 1, '0, 1'b1);
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) y = 0;
    end
    next_col = x;
    next_row = y;
  endfunction

  function automatic logic [lef_pkg::CH_W-1:0] random_level();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 8'hFF;
      default: return lef_pkg::CH_W'($urandom);
    endcase
  endfunction

  function automatic lef_pkg::in_word_t random_pixel();
    lef_pkg::in_word_t px;
    px.red_in   = random_level();
    px.green_in = random_level();
    px.blue_in  = random_level();
    return px;
  endfunction

  // Send one pixel word, with an occasional gap before it
  task automatic send_pixel(lef_pkg::in_word_t px);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    filter_pixel(px);
    pixels_sent++;
  endtask

  // Drop valid, wait for every expected word, then let the pipeline empty
  task automatic settle();
    int unsigned waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (filtered_queue.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (filtered_queue.size() != 0) begin
      report_mismatch($sformatf("%0d expected words never arrived", filtered_queue.size()));
      filtered_queue.delete();
    end
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(lef_pkg::cfg_reg_t idx, int unsigned value);
    logic [lef_pkg::CFG_DATA_W-1:0] data;
    data = value[lef_pkg::CFG_DATA_W-1:0];
    // width ignores the upper data bits
    if (idx == lef_pkg::REG_IMAGE_WIDTH)
      data[lef_pkg::CFG_DATA_W-1:lef_pkg::IMG_W_W] = 2'($urandom);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == lef_pkg::REG_IMAGE_WIDTH)
      img_width_reg = data[lef_pkg::IMG_W_W-1:0];
    else
      img_height_reg = data[lef_pkg::IMG_H_W-1:0];
  endtask

  task automatic finish_image();
    do
      send_pixel(random_pixel());
    while (next_col != 0 || next_row != 0);
  endtask

  function automatic int unsigned pick_size(int unsigned top);
    if ($urandom_range(0, 5) == 0) return $urandom_range(0, 2);
    return $urandom_range(3, top);
  endfunction

  // Reset size 640 x 480: part of row 0, then shrink to end the image
  task automatic test_reset_size();
    repeat (5) send_pixel(random_pixel());
    settle();
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 3);
    write_reg(lef_pkg::REG_IMAGE_HEIGHT, 3);
    finish_image();
  endtask

  function automatic lef_pkg::in_word_t pattern_pixel(int unsigned x, int unsigned y);
    lef_pkg::in_word_t px;
    px.red_in   = (x == 2 && y == 1) ? 8'hFF : 8'h00;  // lone peak: clamps high
    px.green_in = (x == 2 && y == 2) ? 8'h00 : 8'hFF;  // lone pit: clamps low
    px.blue_in  = (x == 1 && y == 1) ? 8'd40 : 8'd30;  // small bump: mid-range value
    return px;
  endfunction

  task automatic test_filter_patterns();
    lef_pkg::in_word_t px;
    settle();
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 5);
    write_reg(lef_pkg::REG_IMAGE_HEIGHT, 4);
    for (int y = 0; y < 4; y++)
      for (int x = 0; x < 5; x++)
        send_pixel(pattern_pixel(x, y));
    // smallest image, reached by sizes below the minimum
    settle();
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 1);
    write_reg(lef_pkg::REG_IMAGE_HEIGHT, 0);
    for (int i = 0; i < 9; i++) begin
      px = (i == 4) ? lef_pkg::in_word_t'({8'hFF, 8'h00, 8'h12})
                    : lef_pkg::in_word_t'({8'h00, 8'hFF, 8'h10});
      send_pixel(px);
    end
  endtask

  // Shrink the size inside an image: row wrap, image wrap, and both at once
  task automatic test_size_changes();
    settle();
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 6);
    write_reg(lef_pkg::REG_IMAGE_HEIGHT, 5);
    repeat (9) send_pixel(random_pixel());
    settle();
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 3);
    repeat (4) send_pixel(random_pixel());
    settle();
    write_reg(lef_pkg::REG_IMAGE_HEIGHT, 3);
    finish_image();
    settle();
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 5);
    write_reg(lef_pkg::REG_IMAGE_HEIGHT, 3);
    repeat (13) send_pixel(random_pixel());
    settle();
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 3);
    finish_image();
  endtask

  task automatic test_random_images();
    int unsigned start, cut;
    start = pixels_sent;
    while (pixels_sent - start < 16) begin
      settle();
      write_reg(lef_pkg::REG_IMAGE_WIDTH, pick_size(6));
      write_reg(lef_pkg::REG_IMAGE_HEIGHT, pick_size(5));
      if ($urandom_range(0, 3) == 0) begin
        cut = $urandom_range(1, eff_width() * eff_height() - 1);
        repeat (cut) send_pixel(random_pixel());
        settle();
        // width only shrinks inside an image; height may go either way
        write_reg(lef_pkg::REG_IMAGE_WIDTH, $urandom_range(0, eff_width()));
        write_reg(lef_pkg::REG_IMAGE_HEIGHT, $urandom_range(0, 7));
      end
      finish_image();
    end
  endtask

  // Width above the maximum saturates: part of row 0, then shrink to wrap the row
  task automatic test_widest_image();
    settle();
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 2047);
    write_reg(lef_pkg::REG_IMAGE_HEIGHT, 3);
    repeat (6) send_pixel(random_pixel());
    settle();
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 3);
    finish_image();
  endtask

  // Height above the maximum saturates: two rows and a bit, then shrink to end
  task automatic test_tallest_image();
    settle();
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 3);
    write_reg(lef_pkg::REG_IMAGE_HEIGHT, 8191);
    repeat (7) send_pixel(random_pixel());
    settle();
    write_reg(lef_pkg::REG_IMAGE_HEIGHT, 3);
    finish_image();
  endtask

  task automatic test_steady_stream();
    idle_en = 1'b0;
    settle();
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 4);
    write_reg(lef_pkg::REG_IMAGE_HEIGHT, 3);
    finish_image();
    settle();
    write_reg(lef_pkg::REG_IMAGE_WIDTH, 3);
    write_reg(lef_pkg::REG_IMAGE_HEIGHT, 3);
    finish_image();
  endtask

  // Receiver stalls in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_result(lef_pkg::out_word_t got);
    lef_pkg::out_word_t want;
    if (filtered_queue.size() == 0) begin
      report_mismatch($sformatf("unexpected word at (%0d,%0d)", got.col_out, got.row_out));
      return;
    end
    want = filtered_queue.pop_front();
    if (got.col_out !== want.col_out)
      report_mismatch($sformatf("col_out %0d, expected %0d", got.col_out, want.col_out));
    if (got.row_out !== want.row_out)
      report_mismatch($sformatf("row_out %0d, expected %0d", got.row_out, want.row_out));
    if (got.red_out !== want.red_out)
      report_mismatch($sformatf("red_out %0d, expected %0d at (%0d,%0d)",
                                got.red_out, want.red_out, want.col_out, want.row_out));
    if (got.green_out !== want.green_out)
      report_mismatch($sformatf("green_out %0d, expected %0d at (%0d,%0d)",
                                got.green_out, want.green_out, want.col_out, want.row_out));
    if (got.blue_out !== want.blue_out)
      report_mismatch($sformatf("blue_out %0d, expected %0d at (%0d,%0d)",
                                got.blue_out, want.blue_out, want.col_out, want.row_out));
    if (got.image_done !== want.image_done)
      report_mismatch($sformatf("image_done %0b, expected %0b at (%0d,%0d)",
                                got.image_done, want.image_done, want.col_out, want.row_out));
  endtask

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      check_result(out_word);
  end

  initial begin
    reset_filter_state();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_size();
    test_filter_patterns();
    test_size_changes();
    test_random_images();
    test_widest_image();
    test_tallest_image();
    test_steady_stream();
    settle();
    repeat (16) @(posedge clk);
    if (err_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Hang guard
  initial begin
    #400_000;
    $display("FAIL");
    $finish;
  end

endmodule
